// ===== hw/rtl/glr_pkg.sv =====
package glr_pkg;

    localparam int CFG_IW = 3;
    localparam int CFG_DW = 15;

    localparam logic [CFG_IW-1:0] CFG_GLYPH_MODE    = 3'd0;
    localparam logic [CFG_IW-1:0] CFG_GLYPH_ROWS    = 3'd1;
    localparam logic [CFG_IW-1:0] CFG_ADVANCE_WIDTH = 3'd2;
    localparam logic [CFG_IW-1:0] CFG_BG_ENABLE     = 3'd3;
    localparam logic [CFG_IW-1:0] CFG_SCREEN_WIDTH  = 3'd4;
    localparam logic [CFG_IW-1:0] CFG_SCREEN_HEIGHT = 3'd5;
    localparam logic [CFG_IW-1:0] CFG_LINE_PITCH    = 3'd6;

    localparam logic        MODE_ASCII  = 1'b0;
    localparam logic        KIND_LOAD   = 1'b0;
    localparam logic [15:0] ASCII_FIRST = 16'd32;
    localparam logic [15:0] ASCII_LAST  = 16'd126;
    localparam int          GLYPH_COLS  = 8;
    localparam logic [7:0]  LEFT_BIT    = 8'h80;

    typedef struct packed {
        logic        glyph_mode;
        logic [5:0]  glyph_rows;
        logic [7:0]  advance_width;
        logic        bg_enable;
        logic [14:0] screen_width;
        logic [14:0] screen_height;
        logic [14:0] line_pitch;
    } t_glr_cfg;

    localparam t_glr_cfg CFG_RESET = '{
        glyph_mode:    1'b0,
        glyph_rows:    6'd16,
        advance_width: 8'd8,
        bg_enable:     1'b0,
        screen_width:  15'd640,
        screen_height: 15'd480,
        line_pitch:    15'd640
    };

endpackage

// ===== hw/rtl/glr_in_if.sv =====
interface glr_in_if;
    logic               valid;
    logic               ready;
    logic               kind;
    logic [12:0]        store_address;
    logic [7:0]         store_byte;
    logic [15:0]        char_code;
    logic signed [15:0] pen_x;
    logic signed [15:0] pen_y;

    modport source (
        output valid, kind, store_address, store_byte, char_code, pen_x, pen_y,
        input  ready
    );
    modport sink (
        input  valid, kind, store_address, store_byte, char_code, pen_x, pen_y,
        output ready
    );
endinterface

// ===== hw/rtl/glr_out_if.sv =====
interface glr_out_if;
    logic               valid;
    logic               ready;
    logic signed [29:0] row_address;
    logic [7:0]         fg_mask;
    logic [7:0]         bg_mask;
    logic [7:0]         advance;
    logic               last_row;

    modport source (
        output valid, row_address, fg_mask, bg_mask, advance, last_row,
        input  ready
    );
    modport sink (
        input  valid, row_address, fg_mask, bg_mask, advance, last_row,
        output ready
    );
endinterface

// ===== hw/rtl/glyph_row_rasterizer.sv =====
// Character generator for an 8-pixel-wide, 1-bit-per-pixel bitmap font.
// Input channel i_in: a beat with kind 0 writes store_byte into the glyph store at
// store_address (wrapped to the store size) and gives no result. A beat with kind 1
// renders char_code at (pen_x, pen_y) and gives one result beat per glyph row on o_out,
// carrying the row's framebuffer offset, clipped foreground and background masks, the
// pen advance and a last_row flag. A code outside the table of the current mode gives
// one all-zero beat with last_row set. Configuration is written through i_cfg_we /
// i_cfg_index / i_cfg_data; the user must write it only while idle, and the block
// does not enforce this. A render goes through the prepare state, then each row
// passes the store read stage and the output register. The row sequencer with its
// address adder and the store's one read port issue one row per cycle while the
// output is not stalled. i_in.ready is high only between characters. When the
// receiver stalls, the output register and the store read stage hold and the
// sequencer waits; no row is lost. Reset restores the register defaults and empties
// the pipeline; the glyph store keeps whatever it held and must be loaded before use.
module glyph_row_rasterizer
    import glr_pkg::*;
#(
    parameter int STORE_BYTES = 8192,
    parameter int MAX_ROWS    = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    glr_in_if.sink            i_in,
    glr_out_if.source         o_out,
    input  logic              i_cfg_we,
    input  logic [CFG_IW-1:0] i_cfg_index,
    input  logic [CFG_DW-1:0] i_cfg_data
);

    localparam int AW  = $clog2(STORE_BYTES);
    localparam int RW  = $clog2(MAX_ROWS);
    localparam int RCW = $clog2(MAX_ROWS + 1);
    localparam int PW  = 8 + RCW;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_PREP  = 2'd1;
    localparam logic [1:0] S_ROW   = 2'd2;
    localparam logic [1:0] S_DRAIN = 2'd3;

    // Reduces a value below 2^14 modulo the store size by subtracting shifted copies.
    function automatic logic [AW-1:0] store_wrap(input logic [13:0] x);
        logic [20:0] v;
        v = 21'(x);
        for (int k = 4; k >= 0; k--) begin
            if (v >= (21'(STORE_BYTES) << k)) begin
                v = v - (21'(STORE_BYTES) << k);
            end
        end
        return v[AW-1:0];
    endfunction

    t_glr_cfg r_cfg;

    logic [1:0]        r_state;
    logic              r_rej;
    logic [PW-1:0]     r_base_prod;
    logic [29:0]       r_addr;
    logic signed [15:0] r_px;
    logic signed [16:0] r_line;
    logic [AW-1:0]     r_ptr;
    logic [RW-1:0]     r_row;
    logic [RW-1:0]     r_last;
    logic [7:0]        r_colvis;

    logic              r_fv;
    logic [29:0]       r_f_addr;
    logic              r_f_rowvis;
    logic              r_f_last;

    logic              r_ov;
    logic [29:0]       r_o_addr;
    logic [7:0]        r_o_fg;
    logic [7:0]        r_o_bg;
    logic [7:0]        r_o_adv;
    logic              r_o_last;

    logic              w_acc;
    logic              w_out_free;
    logic              w_mv;
    logic              w_issue;
    logic              w_ok;
    logic [7:0]        w_index;
    logic [RCW-1:0]    w_rows;
    logic signed [31:0] w_yprod;
    logic [7:0]        w_colvis;
    logic [AW:0]       w_ptr_inc;
    logic [7:0]        w_rdata;
    logic [AW-1:0]     w_waddr;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_GLYPH_MODE:    r_cfg.glyph_mode    <= i_cfg_data[0];
                CFG_GLYPH_ROWS:    r_cfg.glyph_rows    <= i_cfg_data[5:0];
                CFG_ADVANCE_WIDTH: r_cfg.advance_width <= i_cfg_data[7:0];
                CFG_BG_ENABLE:     r_cfg.bg_enable     <= i_cfg_data[0];
                CFG_SCREEN_WIDTH:  r_cfg.screen_width  <= i_cfg_data;
                CFG_SCREEN_HEIGHT: r_cfg.screen_height <= i_cfg_data;
                CFG_LINE_PITCH:    r_cfg.line_pitch    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign i_in.ready = (r_state == S_IDLE) && !r_rej;
    assign w_acc      = i_in.valid && i_in.ready;
    assign w_out_free = !r_ov || o_out.ready;
    assign w_mv       = r_fv && w_out_free;
    assign w_issue    = (r_state == S_ROW) && (!r_fv || w_mv);

    always_comb begin
        if (r_cfg.glyph_mode == MODE_ASCII) begin
            w_ok    = (i_in.char_code >= ASCII_FIRST) && (i_in.char_code <= ASCII_LAST);
            w_index = 8'(i_in.char_code - ASCII_FIRST);
        end else begin
            w_ok    = (i_in.char_code[15:8] == 8'd0);
            w_index = i_in.char_code[7:0];
        end
        if (r_cfg.glyph_rows == 6'd0) begin
            w_rows = RCW'(1);
        end else if (r_cfg.glyph_rows > 6'(MAX_ROWS)) begin
            w_rows = RCW'(MAX_ROWS);
        end else begin
            w_rows = RCW'(r_cfg.glyph_rows);
        end
    end

    assign w_yprod = i_in.pen_y * $signed({1'b0, r_cfg.line_pitch});
    assign w_waddr = store_wrap(14'(i_in.store_address));

    always_comb begin
        logic signed [16:0] col;
        for (int c = 0; c < GLYPH_COLS; c++) begin
            col = 17'(r_px) + 17'(c);
            w_colvis[GLYPH_COLS-1-c] = !col[16] && (col < $signed({2'b0, r_cfg.screen_width}));
        end
    end

    assign w_ptr_inc = {1'b0, r_ptr} + 1'b1;

    glr_store #(
        .DEPTH(STORE_BYTES),
        .AW   (AW)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (w_acc && (i_in.kind == KIND_LOAD)),
        .i_waddr(w_waddr),
        .i_wdata(i_in.store_byte),
        .i_re   (w_issue),
        .i_raddr(r_ptr),
        .o_rdata(w_rdata)
    );

    // Row sequencer: an adder walks the framebuffer offset by the pitch.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_rej   <= 1'b0;
            r_fv    <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (r_rej) begin
                        if (w_out_free) begin
                            r_rej <= 1'b0;
                        end
                    end else if (w_acc && (i_in.kind != KIND_LOAD)) begin
                        if (!w_ok) begin
                            r_rej <= 1'b1;
                        end else begin
                            r_state <= S_PREP;
                        end
                    end
                end
                S_PREP: begin
                    r_state <= S_ROW;
                end
                S_ROW: begin
                    if (w_issue) begin
                        r_fv <= 1'b1;
                        if (r_row == r_last) begin
                            r_state <= S_DRAIN;
                        end
                    end
                end
                S_DRAIN: begin
                    if (w_mv) begin
                        r_fv    <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // A rejected code waits in S_IDLE until the output register is free to take its beat.
    // ready is held low there, so the next beat waits until the reject beat is loaded.

    always_ff @(posedge i_clk) begin
        if (w_acc && (i_in.kind != KIND_LOAD)) begin
            r_base_prod <= PW'(w_index) * PW'(w_rows);
            r_addr      <= w_yprod[29:0];
            r_px        <= i_in.pen_x;
            r_line      <= 17'(i_in.pen_y);
            r_row       <= '0;
            r_last      <= RW'(w_rows - 1'b1);
        end
        if (r_state == S_PREP) begin
            r_ptr    <= store_wrap(14'(r_base_prod));
            r_addr   <= r_addr + 30'(r_px);
            r_colvis <= w_colvis;
        end
        if (w_issue) begin
            r_f_addr   <= r_addr;
            r_f_rowvis <= !r_line[16] && (r_line < $signed({2'b0, r_cfg.screen_height}));
            r_f_last   <= (r_row == r_last);
            r_addr     <= r_addr + 30'(r_cfg.line_pitch);
            r_line     <= r_line + 17'sd1;
            r_row      <= r_row + 1'b1;
            r_ptr      <= (w_ptr_inc == (AW+1)'(STORE_BYTES)) ? '0 : w_ptr_inc[AW-1:0];
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_mv || (r_rej && w_out_free)) begin
            r_ov <= 1'b1;
        end else if (o_out.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_mv) begin
            r_o_addr <= r_f_addr;
            r_o_fg   <= w_rdata & r_colvis & {8{r_f_rowvis}};
            r_o_bg   <= ~w_rdata & r_colvis & {8{r_f_rowvis && r_cfg.bg_enable}};
            r_o_adv  <= r_cfg.advance_width;
            r_o_last <= r_f_last;
        end else if (r_rej && w_out_free) begin
            r_o_addr <= '0;
            r_o_fg   <= '0;
            r_o_bg   <= '0;
            r_o_adv  <= '0;
            r_o_last <= 1'b1;
        end
    end

    assign o_out.valid       = r_ov;
    assign o_out.row_address = $signed(r_o_addr);
    assign o_out.fg_mask     = r_o_fg;
    assign o_out.bg_mask     = r_o_bg;
    assign o_out.advance     = r_o_adv;
    assign o_out.last_row    = r_o_last;

    a_idle_fetch_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_fv)
        else $error("fetch stage holds a row while idle");

    a_row_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROW) |-> (r_row <= r_last))
        else $error("row counter ran past the last glyph row");

    a_masks_disjoint: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov |-> ((r_o_fg & r_o_bg) == 8'd0))
        else $error("pixel marked both foreground and background");

    a_reject_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rej |-> ((r_state == S_IDLE) && !r_fv))
        else $error("reject pending while rows are in flight");

    a_drain_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRAIN) |-> r_f_last)
        else $error("draining without the last row in the fetch stage");

endmodule

// ===== hw/rtl/glr_store.sv =====
module glr_store #(
    parameter int DEPTH = 8192,
    parameter int AW    = 13
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read data holds while no read is issued, so a stalled row keeps its bits.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== bench/glr_row_checker.sv =====
`timescale 1ns / 100ps

module glr_row_checker
    import glr_pkg::*;
#(
    parameter int STORE_BYTES = 8192,
    parameter int MAX_ROWS    = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    glr_in_if                 i_in,
    glr_out_if                i_out,
    input  logic              i_cfg_we,
    input  logic [CFG_IW-1:0] i_cfg_index,
    input  logic [CFG_DW-1:0] i_cfg_data,
    output int                o_mismatches,
    output int                o_rows_due
);

    localparam int PSF_CODES  = 256;
    localparam int REPORT_MAX = 10;

    typedef struct packed {
        logic signed [29:0] row_address;
        logic [7:0]         fg_mask;
        logic [7:0]         bg_mask;
        logic [7:0]         advance;
        logic               last_row;
    } t_row_beat;

    t_row_beat  rows_due[$];
    logic [7:0] glyph_mem [STORE_BYTES];
    t_glr_cfg   cfg = CFG_RESET;
    int         mismatch_cnt = 0;

    // Expands one render beat into the row beats the block must produce for it.
    task automatic rasterize_char(input logic [15:0] code, input logic signed [15:0] px,
                                  input logic signed [15:0] py);
        logic               in_table;
        int                 index;
        int                 rows;
        int                 base;
        logic signed [63:0] line;
        logic signed [63:0] col;
        logic signed [63:0] addr;
        logic signed [63:0] pitch;
        logic signed [63:0] width;
        logic signed [63:0] height;
        logic               row_vis;
        logic [7:0]         bits;
        logic [7:0]         bit_mask;
        t_row_beat          beat;

        if (cfg.glyph_mode == MODE_ASCII) begin
            in_table = code >= ASCII_FIRST && code <= ASCII_LAST;
            index = int'(code) - int'(ASCII_FIRST);
        end else begin
            in_table = int'(code) < PSF_CODES;
            index = int'(code);
        end
        if (!in_table) begin
            beat = '0;
            beat.last_row = 1'b1;
            rows_due.push_back(beat);
            return;
        end

        rows = int'(cfg.glyph_rows);
        if (rows == 0) rows = 1;
        if (rows > MAX_ROWS) rows = MAX_ROWS;
        base = (index * rows) % STORE_BYTES;
        pitch = cfg.line_pitch;
        width = cfg.screen_width;
        height = cfg.screen_height;

        for (int row = 0; row < rows; row++) begin
            line = py;
            line += row;
            addr = line * pitch;
            addr += px;
            row_vis = line >= 0 && line < height;
            bits = glyph_mem[(base + row) % STORE_BYTES];
            beat.fg_mask = '0;
            beat.bg_mask = '0;
            for (int c = 0; c < GLYPH_COLS; c++) begin
                col = px;
                col += c;
                bit_mask = LEFT_BIT >> c;
                if (row_vis && col >= 0 && col < width) begin
                    if ((bits & bit_mask) != 0) beat.fg_mask |= bit_mask;
                    else if (cfg.bg_enable) beat.bg_mask |= bit_mask;
                end
            end
            beat.row_address = addr[29:0];
            beat.advance = cfg.advance_width;
            beat.last_row = (row == rows - 1);
            rows_due.push_back(beat);
        end
    endtask

    task automatic match_row(input t_row_beat got);
        t_row_beat want;

        if (rows_due.size() == 0) begin
            mismatch_cnt++;
            if (mismatch_cnt <= REPORT_MAX)
                $display("%0t: row beat with none due: addr=%0d fg=%h bg=%h adv=%0d last=%b",
                         $time, got.row_address, got.fg_mask, got.bg_mask, got.advance,
                         got.last_row);
            return;
        end
        want = rows_due.pop_front();
        if (got !== want) begin
            mismatch_cnt++;
            if (mismatch_cnt <= REPORT_MAX) begin
                $display("%0t: row beat mismatch", $time);
                $display("    expected addr=%0d fg=%h bg=%h adv=%0d last=%b",
                         want.row_address, want.fg_mask, want.bg_mask, want.advance,
                         want.last_row);
                $display("    actual   addr=%0d fg=%h bg=%h adv=%0d last=%b",
                         got.row_address, got.fg_mask, got.bg_mask, got.advance,
                         got.last_row);
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_row_beat got;

        if (!i_rst_n) begin
            cfg = CFG_RESET;
            rows_due.delete();
        end else begin
            if (i_out.valid && i_out.ready) begin
                got.row_address = i_out.row_address;
                got.fg_mask = i_out.fg_mask;
                got.bg_mask = i_out.bg_mask;
                got.advance = i_out.advance;
                got.last_row = i_out.last_row;
                match_row(got);
            end
            if (i_in.valid && i_in.ready) begin
                if (i_in.kind == KIND_LOAD)
                    glyph_mem[int'(i_in.store_address) % STORE_BYTES] = i_in.store_byte;
                else
                    rasterize_char(i_in.char_code, i_in.pen_x, i_in.pen_y);
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_GLYPH_MODE:    cfg.glyph_mode = i_cfg_data[0];
                    CFG_GLYPH_ROWS:    cfg.glyph_rows = i_cfg_data[5:0];
                    CFG_ADVANCE_WIDTH: cfg.advance_width = i_cfg_data[7:0];
                    CFG_BG_ENABLE:     cfg.bg_enable = i_cfg_data[0];
                    CFG_SCREEN_WIDTH:  cfg.screen_width = i_cfg_data[14:0];
                    CFG_SCREEN_HEIGHT: cfg.screen_height = i_cfg_data[14:0];
                    CFG_LINE_PITCH:    cfg.line_pitch = i_cfg_data[14:0];
                    default: ;
                endcase
            end
        end
        o_mismatches <= mismatch_cnt;
        o_rows_due <= rows_due.size();
    end

endmodule

// ===== bench/tb_glyph_row_rasterizer.sv =====
`timescale 1ns / 100ps

module tb_glyph_row_rasterizer;
    import glr_pkg::*;

    localparam int STORE_BYTES   = 8192;
    localparam int MAX_ROWS      = 32;
    localparam int PSF_CODES     = 256;
    localparam int CODE_MAX      = 65535;
    localparam int DIM_MAX       = 32767;
    localparam int GAP_MAX       = 18;
    localparam int HOLD_CYCLES   = 400;
    localparam int STALL_LIMIT   = 3000;
    localparam int SETTLE_CYCLES = 8;

    localparam logic        MODE_PSF  = 1'b1;
    localparam logic        KIND_DRAW = 1'b1;
    localparam logic [15:0] CODE_A    = 16'd65;
    localparam logic [7:0]  GLYPH_A_ROWS [16] = '{
        8'hFF, 8'h00, 8'h80, 8'h01, 8'hAA, 8'h55, 8'hF0, 8'h0F,
        8'hC3, 8'h3C, 8'h81, 8'h7E, 8'h18, 8'hE7, 8'h24, 8'hDB
    };

    typedef enum logic [1:0] {
        PACE_RANDOM,
        PACE_NO_GAPS,
        PACE_RX_HOLD
    } t_pace;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              cfg_we;
    logic [CFG_IW-1:0] cfg_index;
    logic [CFG_DW-1:0] cfg_data;
    int                mismatches;
    int                rows_due;

    glr_in_if  glyph_in ();
    glr_out_if row_out ();

    t_glr_cfg cur_cfg = CFG_RESET;
    bit       store_written [STORE_BYTES];
    bit       tx_calm = 1'b0;
    bit       rx_calm = 1'b0;
    bit       hold_req = 1'b0;
    int       items_sent = 0;

    always #5 i_clk = ~i_clk;

    glyph_row_rasterizer #(
        .STORE_BYTES(STORE_BYTES),
        .MAX_ROWS   (MAX_ROWS)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (glyph_in),
        .o_out      (row_out),
        .i_cfg_we   (cfg_we),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data)
    );

    glr_row_checker #(
        .STORE_BYTES(STORE_BYTES),
        .MAX_ROWS   (MAX_ROWS)
    ) row_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (glyph_in),
        .i_out       (row_out),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .o_mismatches(mismatches),
        .o_rows_due  (rows_due)
    );

    function automatic int rows_in_use();
        int rows;

        rows = int'(cur_cfg.glyph_rows);
        if (rows == 0) rows = 1;
        if (rows > MAX_ROWS) rows = MAX_ROWS;
        return rows;
    endfunction

    function automatic bit code_in_table(input logic [15:0] code, output int index);
        if (cur_cfg.glyph_mode == MODE_ASCII) begin
            index = int'(code) - int'(ASCII_FIRST);
            return code >= ASCII_FIRST && code <= ASCII_LAST;
        end
        index = int'(code);
        return int'(code) < PSF_CODES;
    endfunction

    // Mostly one of the four codes from the phase's pool onward, so that stored glyphs get reused.
    function automatic logic [15:0] table_code(input int pool);
        int span;
        int offset;

        if (cur_cfg.glyph_mode == MODE_ASCII) begin
            span = int'(ASCII_LAST) - int'(ASCII_FIRST) + 1;
            offset = int'(ASCII_FIRST);
        end else begin
            span = PSF_CODES;
            offset = 0;
        end
        if ($urandom_range(0, 9) != 0)
            return 16'(offset + (pool + int'($urandom_range(0, 3))) % span);
        return 16'(offset + int'($urandom_range(0, span - 1)));
    endfunction

    function automatic logic [15:0] reject_code();
        if (cur_cfg.glyph_mode == MODE_ASCII && $urandom_range(0, 1) == 0)
            return 16'($urandom_range(0, int'(ASCII_FIRST) - 1));
        if (cur_cfg.glyph_mode == MODE_ASCII)
            return 16'($urandom_range(int'(ASCII_LAST) + 1, CODE_MAX));
        return 16'($urandom_range(PSF_CODES, CODE_MAX));
    endfunction

    // Pen positions cluster around the screen edges where clipping happens.
    function automatic logic signed [15:0] pick_pen(input int span);
        case ($urandom_range(0, 4))
            0: return 16'(-int'($urandom_range(0, 9)));
            1: return 16'(span - int'($urandom_range(0, 9)));
            2: return 16'($urandom_range(0, span));
            3: return 16'($urandom);
            default: return 16'($urandom_range(0, 40));
        endcase
    endfunction

    function automatic logic [14:0] pick_dim();
        case ($urandom_range(0, 2))
            0: return 15'($urandom_range(0, 64));
            1: return 15'($urandom_range(65, 2048));
            default: return 15'($urandom_range(0, DIM_MAX));
        endcase
    endfunction

    task automatic send_item(input logic kind, input logic [12:0] addr, input logic [7:0] data,
                             input logic [15:0] code, input logic signed [15:0] px,
                             input logic signed [15:0] py);
        int gap;

        gap = tx_calm ? 0 : $urandom_range(0, GAP_MAX);
        if (gap > 0) begin
            glyph_in.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        glyph_in.valid <= 1'b1;
        glyph_in.kind <= kind;
        glyph_in.store_address <= addr;
        glyph_in.store_byte <= data;
        glyph_in.char_code <= code;
        glyph_in.pen_x <= px;
        glyph_in.pen_y <= py;
        do @(posedge i_clk); while (!glyph_in.ready);
        items_sent++;
    endtask

    task automatic load_byte(input logic [12:0] addr, input logic [7:0] data);
        send_item(KIND_LOAD, addr, data, 16'($urandom), 16'($urandom), 16'($urandom));
        store_written[addr] = 1'b1;
    endtask

    // Any store byte the glyph needs that was never loaded gets a random value first.
    task automatic draw_char(input logic [15:0] code, input logic signed [15:0] px,
                             input logic signed [15:0] py);
        int index;
        int rows;
        int a;

        if (code_in_table(code, index)) begin
            rows = rows_in_use();
            for (int r = 0; r < rows; r++) begin
                a = (index * rows + r) % STORE_BYTES;
                if (!store_written[a]) load_byte(13'(a), 8'($urandom));
            end
        end
        send_item(KIND_DRAW, 13'($urandom), 8'($urandom), code, px, py);
    endtask

    task automatic drain();
        glyph_in.valid <= 1'b0;
        do @(posedge i_clk); while (rows_due != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_regs(input t_glr_cfg c);
        for (int r = 0; r <= int'(CFG_LINE_PITCH); r++) begin
            cfg_we <= 1'b1;
            cfg_index <= CFG_IW'(r);
            case (CFG_IW'(r))
                CFG_GLYPH_MODE:    cfg_data <= CFG_DW'(c.glyph_mode);
                CFG_GLYPH_ROWS:    cfg_data <= CFG_DW'(c.glyph_rows);
                CFG_ADVANCE_WIDTH: cfg_data <= CFG_DW'(c.advance_width);
                CFG_BG_ENABLE:     cfg_data <= CFG_DW'(c.bg_enable);
                CFG_SCREEN_WIDTH:  cfg_data <= CFG_DW'(c.screen_width);
                CFG_SCREEN_HEIGHT: cfg_data <= CFG_DW'(c.screen_height);
                CFG_LINE_PITCH:    cfg_data <= CFG_DW'(c.line_pitch);
                default:           cfg_data <= '0;
            endcase
            @(posedge i_clk);
        end
        cfg_we <= 1'b0;
        cur_cfg = c;
    endtask

    task automatic run_phase(input t_glr_cfg c, input int budget, input t_pace pace);
        int          start;
        int          roll;
        int          pool;
        int          index;
        int          rows;
        int          w;
        int          h;
        logic [15:0] code;
        logic [15:0] last_code;

        drain();
        write_regs(c);
        tx_calm = pace != PACE_RANDOM || $urandom_range(0, 3) == 0;
        rx_calm = pace == PACE_NO_GAPS || (pace == PACE_RANDOM && $urandom_range(0, 3) == 0);
        hold_req = pace == PACE_RX_HOLD;
        pool = $urandom_range(0, PSF_CODES - 1);
        w = int'(c.screen_width);
        h = int'(c.screen_height);

        // Both ends of the code table and the first code past it.
        last_code = (c.glyph_mode == MODE_ASCII) ? ASCII_LAST : 16'(PSF_CODES - 1);
        draw_char((c.glyph_mode == MODE_ASCII) ? ASCII_FIRST : 16'd0, pick_pen(w), pick_pen(h));
        draw_char(last_code, pick_pen(w), pick_pen(h));
        draw_char(last_code + 16'd1, pick_pen(w), pick_pen(h));

        start = items_sent;
        while (items_sent - start < budget) begin
            roll = $urandom_range(0, 99);
            if (roll < 12) begin
                load_byte(13'($urandom), 8'($urandom));
            end else if (roll < 25) begin
                draw_char(reject_code(), pick_pen(w), pick_pen(h));
            end else begin
                code = table_code(pool);
                // A fresh glyph load followed by its render.
                if (roll < 45 && code_in_table(code, index)) begin
                    rows = rows_in_use();
                    for (int r = 0; r < rows; r++)
                        load_byte(13'((index * rows + r) % STORE_BYTES), 8'($urandom));
                end
                draw_char(code, pick_pen(w), pick_pen(h));
            end
        end
    endtask

    initial begin
        int       index;
        int       rows;
        t_glr_cfg c;

        glyph_in.valid <= 1'b0;
        glyph_in.kind <= KIND_LOAD;
        glyph_in.store_address <= '0;
        glyph_in.store_byte <= '0;
        glyph_in.char_code <= '0;
        glyph_in.pen_x <= '0;
        glyph_in.pen_y <= '0;
        cfg_we <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        i_rst_n <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part on the reset settings.
        void'(code_in_table(CODE_A, index));
        rows = rows_in_use();
        for (int r = 0; r < rows; r++)
            load_byte(13'((index * rows + r) % STORE_BYTES), GLYPH_A_ROWS[r]);
        draw_char(CODE_A, 16'sd0, 16'sd0);
        draw_char(CODE_A, -16'sd3, -16'sd2);
        draw_char(CODE_A, 16'sd636, 16'sd476);
        draw_char(CODE_A, 16'sh7FFF, 16'sh7FFF);
        draw_char(CODE_A, 16'sh8000, 16'sh8000);
        draw_char(ASCII_FIRST - 16'd1, 16'sd5, 16'sd5);
        draw_char(ASCII_LAST + 16'd1, 16'sd5, 16'sd5);
        draw_char(16'd0, 16'sd0, 16'sd0);
        draw_char(16'hFFFF, 16'sd0, 16'sd0);

        run_phase('{glyph_mode: MODE_PSF, glyph_rows: 6'd8, advance_width: 8'd255,
                    bg_enable: 1'b1, screen_width: 15'd100, screen_height: 15'd50,
                    line_pitch: 15'd128}, 30, PACE_RANDOM);
        run_phase('{glyph_mode: MODE_ASCII, glyph_rows: 6'd1, advance_width: 8'd0,
                    bg_enable: 1'b1, screen_width: 15'd0, screen_height: 15'd0,
                    line_pitch: 15'd1}, 20, PACE_NO_GAPS);
        run_phase('{glyph_mode: MODE_PSF, glyph_rows: 6'd32, advance_width: 8'd7,
                    bg_enable: 1'b0, screen_width: 15'h7FFF, screen_height: 15'h7FFF,
                    line_pitch: 15'h7FFF}, 80, PACE_RX_HOLD);
        run_phase('{glyph_mode: MODE_PSF, glyph_rows: 6'd0, advance_width: 8'd129,
                    bg_enable: 1'b1, screen_width: 15'd8, screen_height: 15'd4,
                    line_pitch: 15'd8}, 20, PACE_RANDOM);
        run_phase('{glyph_mode: MODE_ASCII, glyph_rows: 6'd63, advance_width: 8'd200,
                    bg_enable: 1'b1, screen_width: 15'd16384, screen_height: 15'd16384,
                    line_pitch: 15'd16384}, 50, PACE_RANDOM);
        for (int k = 0; k < 2; k++) begin
            c.glyph_mode = 1'($urandom_range(0, 1));
            c.glyph_rows = ($urandom_range(0, 4) != 0) ? 6'($urandom_range(1, 12))
                                                       : 6'($urandom_range(0, 63));
            c.advance_width = 8'($urandom);
            c.bg_enable = 1'($urandom_range(0, 1));
            c.screen_width = pick_dim();
            c.screen_height = pick_dim();
            c.line_pitch = pick_dim();
            run_phase(c, 30, PACE_RANDOM);
        end

        drain();
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Output side: random stalls per beat, and one long hold-off when asked for.
    initial begin
        int stall;

        row_out.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                stall = HOLD_CYCLES;
            end else begin
                stall = rx_calm ? 0 : $urandom_range(0, GAP_MAX);
            end
            if (stall > 0) begin
                row_out.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            row_out.ready <= 1'b1;
            do @(posedge i_clk); while (!row_out.valid);
        end
    end

    initial begin
        int idle_cycles;

        idle_cycles = 0;
        do @(posedge i_clk); while (!i_rst_n);
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((glyph_in.valid && glyph_in.ready) || (row_out.valid && row_out.ready) ||
                cfg_we)
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("tb: failure");
        $finish;
    end

endmodule
